FILE: rtl/dep_pkg.sv
// ----------------------------------------------------------------------------
// dep_pkg
// Shared constants, operation codes and controller/datapath handshake types
// for the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = ADDR_W + 1;

    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_DEL_MAX = 2'd1;
    localparam logic [1:0] KIND_DEL_MIN = 2'd2;
    localparam logic [1:0] KIND_CLEAR   = 2'd3;

    typedef struct packed {
        logic load;      // take a new operation
        logic rd_step;   // read entry below the insert position
        logic move;      // shift the read entry up one place
        logic place;     // write the new key at the insert position
        logic rd_lo;     // read smallest entry
        logic rd_hi;     // capture smallest, read largest
        logic latch_hi;  // capture largest
        logic put;       // load the result register
    } cmd_t;

    typedef struct packed {
        logic ins_go;    // incoming op is an insert with room left
        logic pos_zero;
        logic gt;        // read entry greater than key
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/dep_if.sv
// ----------------------------------------------------------------------------
// dep_if
// Valid/ready channels: operation beats in, status beats out.
// ----------------------------------------------------------------------------
interface dep_op_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] value;
    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface

interface dep_res_if;
    logic        valid;
    logic        ready;
    logic        is_empty;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] max_value;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] min_value;
    logic [10:0] entry_count;
    logic        dropped;
    modport source (output valid, is_empty, max_value, min_value, entry_count, dropped,
                    input ready);
    modport sink   (input valid, is_empty, max_value, min_value, entry_count, dropped,
                    output ready);
endinterface

FILE: rtl/double_ended_priority_queue.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded multiset of signed values with insert, remove-max, remove-min, clear.
// ----------------------------------------------------------------------------
// Channels: op (sink) carries kind and value; res (source) carries one status
// beat per op: is_empty, max_value, min_value, entry_count, dropped.
// Values sit in ascending order in a circular single-write RAM; the head
// pointer advances on remove-min, the count shrinks on remove-max.
// Step order per op: accept in S_IDLE; an insert with room then scans down
// from the top, S_RD reading the entry below the insert position and S_CMP
// moving it up while it is greater than the new value, until the key is
// placed above a smaller or equal entry or at the bottom; every op then
// reads smallest and largest (S_LO, S_HI, S_LATCH) and loads the result in S_PUT.
// The next op is accepted on the cycle after the result is loaded.
// Reset empties the store at once; RAM contents need no clearing.
// If res stalls, the finished result holds in the output register, the next
// op is still taken and runs; it waits at the end until res drains.
// ----------------------------------------------------------------------------
module double_ended_priority_queue (
    input logic     clk,
    input logic     rst_n,
    dep_op_if.sink  op,
    dep_res_if.source res
);

    dep_pkg::cmd_t  cmd;
    dep_pkg::stat_t stat;

    dep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (op.valid),
        .in_ready (op.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dep_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_kind      (op.kind),
        .in_value     (op.value),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (res.ready),
        .out_valid    (res.valid),
        .out_is_empty (res.is_empty),
        .out_max      (res.max_value),
        .out_min      (res.min_value),
        .out_count    (res.entry_count),
        .out_dropped  (res.dropped)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.entry_count <= 11'(dep_pkg::CAPACITY)))
        else $error("entry_count above capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.is_empty == (res.entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.dropped) |-> (res.entry_count == 11'(dep_pkg::CAPACITY)))
        else $error("drop reported with room left");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> !cmd.put)
        else $error("result loaded twice for one op");

endmodule

FILE: rtl/dep_datapath.sv
// ----------------------------------------------------------------------------
// dep_datapath
// Circular sorted store in a RAM, head pointer, fill count, insert scan
// position and the result register.
// ----------------------------------------------------------------------------
module dep_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [1:0]                            in_kind,
    input  logic signed [dep_pkg::VALUE_WIDTH-1:0] in_value,
    input  dep_pkg::cmd_t                         cmd,
    output dep_pkg::stat_t                        stat,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  out_is_empty,
    output logic signed [dep_pkg::VALUE_WIDTH-1:0] out_max,
    output logic signed [dep_pkg::VALUE_WIDTH-1:0] out_min,
    output logic [10:0]                           out_count,
    output logic                                  out_dropped
);

    logic signed [dep_pkg::VALUE_WIDTH-1:0] mem [dep_pkg::CAPACITY];

    logic [dep_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [dep_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [dep_pkg::CNT_W-1:0]  pos_reg, pos_next;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] key_reg;
    logic                       drop_reg;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] rdata_reg;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] lo_reg;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] hi_reg;
    logic                       out_valid_reg;

    logic [dep_pkg::CNT_W-1:0]  pos_m1;
    logic [dep_pkg::CNT_W-1:0]  tail_ofs;
    logic [dep_pkg::ADDR_W-1:0] raddr;
    logic [dep_pkg::ADDR_W-1:0] waddr;
    logic                       rd_en;
    logic                       wr_en;
    logic signed [dep_pkg::VALUE_WIDTH-1:0] wdata;
    logic                       full;
    logic                       empty;

    assign pos_m1   = pos_reg - 1'b1;
    assign tail_ofs = count_reg - 1'b1;
    assign full     = (count_reg == dep_pkg::CNT_W'(dep_pkg::CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        rd_en = cmd.rd_step | cmd.rd_lo | cmd.rd_hi;
        if (cmd.rd_step)
        begin
            raddr = head_reg + pos_m1[dep_pkg::ADDR_W-1:0];
        end
        else if (cmd.rd_hi)
        begin
            raddr = head_reg + tail_ofs[dep_pkg::ADDR_W-1:0];
        end
        else
        begin
            raddr = head_reg;
        end
        wr_en = cmd.move | cmd.place;
        waddr = head_reg + pos_reg[dep_pkg::ADDR_W-1:0];
        wdata = cmd.move ? rdata_reg : key_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        if (cmd.load)
        begin
            pos_next = count_reg;
            unique case (in_kind)
                dep_pkg::KIND_INSERT:  ;
                dep_pkg::KIND_DEL_MAX:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                dep_pkg::KIND_DEL_MIN:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - 1'b1;
                        head_next  = head_reg + 1'b1;
                    end
                end
                dep_pkg::KIND_CLEAR:   count_next = '0;
                default:               ;
            endcase
        end
        if (cmd.move)
        begin
            pos_next = pos_m1;
        end
        if (cmd.place)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            if (cmd.put)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= in_value;
            drop_reg <= (in_kind == dep_pkg::KIND_INSERT) && full;
        end
        if (cmd.rd_hi)
        begin
            lo_reg <= rdata_reg;
        end
        if (cmd.latch_hi)
        begin
            hi_reg <= rdata_reg;
        end
        if (cmd.put)
        begin
            out_is_empty <= empty;
            out_max      <= empty ? '0 : hi_reg;
            out_min      <= empty ? '0 : lo_reg;
            out_count    <= 11'(count_reg);
            out_dropped  <= drop_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.ins_go   = (in_kind == dep_pkg::KIND_INSERT) && !full;
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.gt       = (rdata_reg > key_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

FILE: rtl/dep_ctrl.sv
// ----------------------------------------------------------------------------
// dep_ctrl
// Sequencer: insert scan from the top of the store, then min/max readback
// and result hand-off.
// ----------------------------------------------------------------------------
module dep_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dep_pkg::stat_t stat,
    output dep_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_LO    = 3'd3;
    localparam logic [2:0] S_HI    = 3'd4;
    localparam logic [2:0] S_LATCH = 3'd5;
    localparam logic [2:0] S_PUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.ins_go ? S_RD : S_LO;
                end
            end
            S_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = S_LO;
                end
                else
                begin
                    cmd.rd_step = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.gt)
                begin
                    cmd.move   = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = S_LO;
                end
            end
            S_LO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_HI;
            end
            S_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.latch_hi = 1'b1;
                state_next   = S_PUT;
            end
            S_PUT:
            begin
                if (stat.out_free)
                begin
                    cmd.put    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule
